FILE: rtl/bia_pkg.sv
// Shared types, codes and helper functions of the bitmap index allocator.
`default_nettype none
package bia_pkg;

    localparam int MaxIndices = 1024;
    localparam int WordBits   = 64;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INDEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_SKIP_ZERO   = 2'd1;

    typedef enum logic [2:0] {
        F_LOWEST = 3'd0,
        F_HIGH   = 3'd1,
        F_BLOCK  = 3'd2,
        F_GIVEN  = 3'd3,
        F_FREE   = 3'd4,
        F_QUERY  = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_OOR       = 3'd2,
        ST_DUP_ALLOC = 3'd3,
        ST_DUP_FREE  = 3'd4,
        ST_INVALID   = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]  func;
        logic [9:0]  target_index;
        logic [10:0] block_length;
    } t_bia_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  result_index;
        logic        is_allocated;
        logic [10:0] count_in_use;
    } t_bia_res;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_RD, S_EV, S_BSCAN, S_SRD, S_SEV, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE, WR_LOW, WR_HIGH, WR_SET_TGT, WR_CLR_TGT, WR_MASK
    } t_wr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    rd;
        logic    w_inc;
        logic    w_dec;
        logic    bscan_step;
        logic    blk_start;
        logic    blk_done;
        t_wr     wr;
        logic    st_en;
        t_status st;
        logic    isal_en;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] func;
        logic       invalid;
        logic       tgt_oor;
        logic       blen_zero;
        logic       word_full;
        logic       first_w;
        logic       last_w;
        logic       hi_full;
        logic       tgt_bit;
        logic       bs_found;
        logic       bs_at_end;
        logic       bs_last_bit;
        logic       blk_last_w;
        logic       out_free;
    } t_sts;

    // Position of the lowest set bit; 63 when none is set.
    function automatic logic [5:0] lowest_one(input logic [63:0] v);
        logic [5:0] r;
        r = 6'd63;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bia_datapath.sv
// Datapath of the bitmap index allocator: map memory, pointers, count and result.
`default_nettype none
module bia_datapath #(
    parameter int MAX_INDICES = bia_pkg::MaxIndices
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bia_pkg::t_bia_req i_req,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [10:0]      i_cfg_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output bia_pkg::t_bia_res     o_out,
    input  wire bia_pkg::t_cmd    i_cmd,
    output bia_pkg::t_sts         o_sts
);

    // Indices above 2047 cannot be named by the 11-bit count register.
    localparam int CAP   = (MAX_INDICES < 2047) ? MAX_INDICES : 2047;
    localparam int DEPTH = (CAP + 63) / 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [10:0] CAP_C = 11'(CAP);
    localparam logic [63:0] ALL   = {64{1'b1}};

    logic [10:0]       r_idx_cnt;
    logic              r_skip;
    logic              r_rsv;
    logic [10:0]       r_cnt, n_cnt;
    bia_pkg::t_bia_req r_req;
    logic [5:0]        r_w;
    logic [5:0]        r_bit;
    logic [10:0]       r_run;
    logic [10:0]       r_start;
    logic [10:0]       r_end;
    bia_pkg::t_status  r_st;
    logic [9:0]        r_ridx;
    logic              r_isal;
    logic [63:0]       mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [63:0]       r_rdata;
    logic              r_rvld;
    bia_pkg::t_bia_res r_out;
    logic              r_out_valid;

    logic        cfg_init;
    logic [10:0] eff;
    logic [5:0]  nw;
    logic [5:0]  rem;
    logic [AW-1:0] addr;
    logic [63:0] raw, ew;
    logic [5:0]  lz, lo, hi_pos, tgt_pos, wpos, lo_m, hi_m;
    logic [11:0] bit_i, start_w;
    logic [10:0] run_n;
    logic [63:0] mask, wdata;
    logic [11:0] widx;
    logic        counted;

    assign o_cfg_ready = 1'b1;
    assign cfg_init = i_cfg_valid &&
                      (i_cfg_index == bia_pkg::CFG_INDEX_COUNT ||
                       i_cfg_index == bia_pkg::CFG_SKIP_ZERO);

    // Effective map size and word geometry.
    assign eff  = (r_idx_cnt > CAP_C) ? CAP_C : r_idx_cnt;
    assign nw   = 6'((12'(eff) + 12'd63) >> 6);
    assign rem  = eff[5:0];
    assign addr = r_w[AW-1:0];

    // Word as stored, and with the unusable top bits of the last word forced set.
    assign raw = r_rvld ? r_rdata : {63'b0, (r_w == 6'd0) && r_rsv};
    assign ew  = raw | ((rem != 6'd0 && r_w == {1'b0, eff[10:6]}) ? (ALL << rem) : 64'd0);
    assign lz  = bia_pkg::lowest_one(~ew);
    assign lo  = bia_pkg::lowest_one(ew);
    assign hi_pos  = (ew == 64'd0) ? 6'd63 : lo - 6'd1;
    assign tgt_pos = r_req.target_index[5:0];

    // Bit-serial run search of the block allocation.
    assign bit_i   = {r_w, r_bit};
    assign run_n   = raw[r_bit] ? 11'd0 : r_run + 11'd1;
    assign start_w = bit_i + 12'd1 - {1'b0, r_req.block_length};

    // Mask of the run within the current word.
    assign lo_m = (r_w == {1'b0, r_start[10:6]}) ? r_start[5:0] : 6'd0;
    assign hi_m = (r_w == {1'b0, r_end[10:6]}) ? r_end[5:0] : 6'd63;
    assign mask = (ALL << lo_m) & (ALL >> (6'd63 - hi_m));

    // Write data and the index that a single-bit write touches.
    always_comb begin
        wpos  = tgt_pos;
        wdata = raw;
        case (i_cmd.wr)
            bia_pkg::WR_LOW: begin
                wpos  = lz;
                wdata = raw | (64'd1 << lz);
            end
            bia_pkg::WR_HIGH: begin
                wpos  = hi_pos;
                wdata = raw | (64'd1 << hi_pos);
            end
            bia_pkg::WR_SET_TGT: begin
                wdata = raw | (64'd1 << tgt_pos);
            end
            bia_pkg::WR_CLR_TGT: begin
                wdata = raw & ~(64'd1 << tgt_pos);
            end
            bia_pkg::WR_MASK: begin
                wdata = raw | mask;
            end
            default: begin
                wdata = raw;
            end
        endcase
    end
    assign widx    = {r_w, wpos};
    assign counted = !(r_skip && widx == 12'd0);

    // Count of indices in use.
    always_comb begin
        n_cnt = r_cnt;
        case (i_cmd.wr)
            bia_pkg::WR_LOW, bia_pkg::WR_HIGH, bia_pkg::WR_SET_TGT: begin
                n_cnt = r_cnt + {10'b0, counted};
            end
            bia_pkg::WR_CLR_TGT: begin
                n_cnt = r_cnt - {10'b0, counted};
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
        if (i_cmd.blk_done) begin
            n_cnt = r_cnt + r_req.block_length
                    - {10'b0, r_skip && r_start == 11'd0};
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx_cnt <= 11'd1024;
            r_skip    <= 1'b0;
            r_rsv     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bia_pkg::CFG_INDEX_COUNT: begin
                    r_idx_cnt <= i_cfg_data;
                    r_rsv     <= r_skip && i_cfg_data != 11'd0;
                end
                bia_pkg::CFG_SKIP_ZERO: begin
                    r_skip <= i_cfg_data[0];
                    r_rsv  <= i_cfg_data[0] && eff != 11'd0;
                end
                default: begin
                end
            endcase
        end
    end

    // Count and word valid bits; a configuration write clears the map.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_init) begin
            r_cnt <= 11'd0;
            r_vld <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.wr != bia_pkg::WR_NONE) begin
                r_vld[addr] <= 1'b1;
            end
        end
    end

    // Map memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr != bia_pkg::WR_NONE) begin
            mem[addr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[addr];
            r_rvld  <= r_vld[addr];
        end
    end

    // Request, pointers and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= i_req;
            r_run  <= 11'd0;
            r_bit  <= 6'd0;
            r_st   <= bia_pkg::ST_OK;
            r_ridx <= 10'd0;
            r_isal <= 1'b0;
            if (i_req.func == bia_pkg::F_HIGH) begin
                r_w <= nw - 6'd1;
            end else if (i_req.func == bia_pkg::F_GIVEN || i_req.func == bia_pkg::F_FREE ||
                         i_req.func == bia_pkg::F_QUERY) begin
                r_w <= {2'b0, i_req.target_index[9:6]};
            end else begin
                r_w <= 6'd0;
            end
        end else begin
            if (i_cmd.blk_start) begin
                r_w <= start_w[11:6];
            end else if (i_cmd.w_inc) begin
                r_w <= r_w + 6'd1;
            end else if (i_cmd.w_dec) begin
                r_w <= r_w - 6'd1;
            end
            if (i_cmd.bscan_step) begin
                r_run <= run_n;
                r_bit <= r_bit + 6'd1;
            end
            if (i_cmd.blk_start) begin
                r_start <= start_w[10:0];
                r_end   <= bit_i[10:0];
                r_ridx  <= start_w[9:0];
            end
            if (i_cmd.wr == bia_pkg::WR_LOW || i_cmd.wr == bia_pkg::WR_HIGH ||
                i_cmd.wr == bia_pkg::WR_SET_TGT) begin
                r_ridx <= widx[9:0];
            end
            if (i_cmd.st_en) begin
                r_st <= i_cmd.st;
            end
            if (i_cmd.isal_en) begin
                r_isal <= raw[tgt_pos];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= '{status: r_st, result_index: r_ridx, is_allocated: r_isal,
                       count_in_use: r_cnt};
        end
    end
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status for the controller.
    always_comb begin
        o_sts.func        = r_req.func;
        o_sts.invalid     = eff == 11'd0 || r_req.func > bia_pkg::F_QUERY;
        o_sts.tgt_oor     = {1'b0, r_req.target_index} >= eff;
        o_sts.blen_zero   = r_req.block_length == 11'd0;
        o_sts.word_full   = ew == ALL;
        o_sts.first_w     = r_w == 6'd0;
        o_sts.last_w      = r_w + 6'd1 == nw;
        o_sts.hi_full     = ew != 64'd0 && lo == 6'd0;
        o_sts.tgt_bit     = raw[tgt_pos];
        o_sts.bs_found    = run_n == r_req.block_length;
        o_sts.bs_at_end   = bit_i + 12'd1 == {1'b0, eff};
        o_sts.bs_last_bit = r_bit == 6'd63;
        o_sts.blk_last_w  = r_w == {1'b0, r_end[10:6]};
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    // The count never exceeds the map capacity CAP.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C)
        else $error("count in use above map size");

    // A configuration write leaves an empty map.
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_init |=> (r_cnt == 11'd0 && r_vld == '0))
        else $error("map not cleared by configuration write");

    // A waiting result beat stays valid and steady until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while waiting");

endmodule
`default_nettype wire

FILE: rtl/bia_ctrl.sv
// Controller state machine of the bitmap index allocator.
`default_nettype none
module bia_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bia_pkg::t_sts i_sts,
    output bia_pkg::t_cmd      o_cmd
);

    bia_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bia_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bia_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bia_pkg::S_DEC;
            end
            bia_pkg::S_DEC: begin
                if (i_sts.invalid) begin
                    n_state = bia_pkg::S_DONE;
                end else begin
                    case (i_sts.func) inside
                        bia_pkg::F_LOWEST, bia_pkg::F_HIGH: n_state = bia_pkg::S_RD;
                        bia_pkg::F_BLOCK:
                            n_state = i_sts.blen_zero ? bia_pkg::S_DONE : bia_pkg::S_RD;
                        default:
                            n_state = i_sts.tgt_oor ? bia_pkg::S_DONE : bia_pkg::S_RD;
                    endcase
                end
            end
            bia_pkg::S_RD: n_state = bia_pkg::S_EV;
            bia_pkg::S_EV: begin
                case (i_sts.func) inside
                    bia_pkg::F_LOWEST:
                        n_state = (i_sts.word_full && !i_sts.last_w) ?
                                  bia_pkg::S_RD : bia_pkg::S_DONE;
                    bia_pkg::F_HIGH:
                        n_state = (i_sts.word_full && !i_sts.first_w) ?
                                  bia_pkg::S_RD : bia_pkg::S_DONE;
                    bia_pkg::F_BLOCK: n_state = bia_pkg::S_BSCAN;
                    default: n_state = bia_pkg::S_DONE;
                endcase
            end
            bia_pkg::S_BSCAN: begin
                if (i_sts.bs_found) n_state = bia_pkg::S_SRD;
                else if (i_sts.bs_at_end) n_state = bia_pkg::S_DONE;
                else if (i_sts.bs_last_bit) n_state = bia_pkg::S_RD;
            end
            bia_pkg::S_SRD: n_state = bia_pkg::S_SEV;
            bia_pkg::S_SEV: n_state = i_sts.blk_last_w ? bia_pkg::S_DONE : bia_pkg::S_SRD;
            bia_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = bia_pkg::S_IDLE;
            end
            default: n_state = bia_pkg::S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bia_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            bia_pkg::S_DEC: begin
                if (i_sts.invalid) begin
                    o_cmd.st_en = 1'b1;
                    o_cmd.st    = bia_pkg::ST_INVALID;
                end else if (i_sts.tgt_oor && (i_sts.func == bia_pkg::F_GIVEN ||
                             i_sts.func == bia_pkg::F_FREE ||
                             i_sts.func == bia_pkg::F_QUERY)) begin
                    o_cmd.st_en = 1'b1;
                    o_cmd.st    = bia_pkg::ST_OOR;
                end
            end
            bia_pkg::S_RD, bia_pkg::S_SRD: o_cmd.rd = 1'b1;
            bia_pkg::S_EV: begin
                case (i_sts.func) inside
                    bia_pkg::F_LOWEST: begin
                        if (!i_sts.word_full) begin
                            o_cmd.wr = bia_pkg::WR_LOW;
                        end else if (i_sts.last_w) begin
                            o_cmd.st_en = 1'b1;
                            o_cmd.st    = bia_pkg::ST_FULL;
                        end else begin
                            o_cmd.w_inc = 1'b1;
                        end
                    end
                    bia_pkg::F_HIGH: begin
                        if (i_sts.word_full && !i_sts.first_w) begin
                            o_cmd.w_dec = 1'b1;
                        end else if (i_sts.hi_full) begin
                            o_cmd.st_en = 1'b1;
                            o_cmd.st    = bia_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr = bia_pkg::WR_HIGH;
                        end
                    end
                    bia_pkg::F_GIVEN: begin
                        if (i_sts.tgt_bit) begin
                            o_cmd.st_en = 1'b1;
                            o_cmd.st    = bia_pkg::ST_DUP_ALLOC;
                        end else begin
                            o_cmd.wr = bia_pkg::WR_SET_TGT;
                        end
                    end
                    bia_pkg::F_FREE: begin
                        if (i_sts.tgt_bit) begin
                            o_cmd.wr = bia_pkg::WR_CLR_TGT;
                        end else begin
                            o_cmd.st_en = 1'b1;
                            o_cmd.st    = bia_pkg::ST_DUP_FREE;
                        end
                    end
                    bia_pkg::F_QUERY: o_cmd.isal_en = 1'b1;
                    default: begin
                    end
                endcase
            end
            bia_pkg::S_BSCAN: begin
                o_cmd.bscan_step = 1'b1;
                if (i_sts.bs_found) begin
                    o_cmd.blk_start = 1'b1;
                end else if (i_sts.bs_at_end) begin
                    o_cmd.st_en = 1'b1;
                    o_cmd.st    = bia_pkg::ST_FULL;
                end else if (i_sts.bs_last_bit) begin
                    o_cmd.w_inc = 1'b1;
                end
            end
            bia_pkg::S_SEV: begin
                o_cmd.wr = bia_pkg::WR_MASK;
                if (i_sts.blk_last_w) o_cmd.blk_done = 1'b1;
                else o_cmd.w_inc = 1'b1;
            end
            bia_pkg::S_DONE: o_cmd.out_load = i_sts.out_free;
            default: begin
            end
        endcase
    end

    // A map write always follows the read of the same word.
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr != bia_pkg::WR_NONE |-> $past(o_cmd.rd))
        else $error("map write without a preceding read");

    // Loading a result returns the controller to idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == bia_pkg::S_IDLE)
        else $error("result loaded but controller not idle");

    // The bit scan runs only for block allocation.
    a_scan_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bia_pkg::S_BSCAN |-> i_sts.func == bia_pkg::F_BLOCK)
        else $error("bit scan outside block allocation");

endmodule
`default_nettype wire

FILE: rtl/bitmap_index_allocator.sv
// Top level of the bitmap index allocator.
//
// One request is taken at a time. The map lives in a single-port memory of 64-bit
// words with a registered read, and every word visited is first read, then
// evaluated or written back. Allocate given, free and query visit only the word
// that holds the target; allocate lowest and allocate high scan word by word from
// their end of the map. Allocate block checks one bit per cycle between word
// fetches, then reads and marks each word of the run that it found.
// A result waits in an output register while the next request is taken.
// Configuration writes are taken in any cycle, clear the map at once, and must be
// issued only while no request is in flight.
`default_nettype none
module bitmap_index_allocator #(
    parameter int MAX_INDICES = bia_pkg::MaxIndices
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire bia_pkg::t_bia_req i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output bia_pkg::t_bia_res      o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [10:0]       i_cfg_data
);

    bia_pkg::t_cmd cmd;
    bia_pkg::t_sts sts;

    // Sequencer.
    bia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Map, count and result registers.
    bia_datapath #(
        .MAX_INDICES (MAX_INDICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
`default_nettype wire
